/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the one-wire bus master.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every rising clock edge outside reset.
`define OWBM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("one-wire master check failed");

// Check that a condition implies another at the same clock edge.
`define OWBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one-wire master implication failed");

`else

`define OWBM_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define OWBM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/owbm_pkg.sv */
// Types and constants of the one-wire bus master.
package owbm_pkg;

    // Commands carried by a request
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Line drive codes
    localparam logic [1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [1:0] DRIVE_LOW     = 2'd1;
    localparam logic [1:0] DRIVE_HIGH    = 2'd2;

    // Slot phases
    localparam logic [1:0] PHASE_LOW  = 2'd0;
    localparam logic [1:0] PHASE_MID  = 2'd1;
    localparam logic [1:0] PHASE_TAIL = 2'd2;

    // Timing register indexes
    localparam int NUM_REGS = 8;
    localparam int TIME_W   = 10;
    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_SMPL = 3'd1;
    localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [2:0] REG_READ_SMPL     = 3'd4;
    localparam logic [2:0] REG_READ_TAIL     = 3'd5;
    localparam logic [2:0] REG_WRITE_HOLD    = 3'd6;
    localparam logic [2:0] REG_RECOVERY      = 3'd7;

    typedef logic [TIME_W-1:0] time_val_t;

    localparam time_val_t CFG_RESET [NUM_REGS] = '{
        10'd480, 10'd100, 10'd380, 10'd2, 10'd10, 10'd49, 10'd58, 10'd1
    };

    // Running operation; codes match the commands that start them
    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] write_byte;
        logic       line_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } out_item_t;

endpackage

/* rtl/core/one_wire_bus_master_top.sv */
// One-wire bus master: command sequencer, timing registers and result register.
//
//   channel   direction  handshake           payload
//   in        request    in_valid/in_stall   in_data  (command, write_byte, line_in)
//   out       result     out_valid/out_stall out_data (line_drive, busy_res, ...)
//   cfg       APB write  psel/penable/pwrite paddr, pwdata, prdata
//
// Every request yields one result, registered in the cycle after it is taken; a new request is taken every
// cycle while the result register does not stall, set by the single sequencer update into the result register.
// The result register frees the input side whenever it is empty or being taken.
// Reset clears the sequencer, drops the result and loads the default timings.
// A stalled result holds and stalls the input side only while it is held.
module one_wire_bus_master_top
    import owbm_pkg::*;
#(
    parameter int BITS_PER_BYTE = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam logic [3:0] BIT_LIMIT = 4'(BITS_PER_BYTE);

    time_val_t  cfg_reg [NUM_REGS];

    op_t        op_reg, op_next;
    logic [1:0] phase_reg, phase_next;
    time_val_t  time_reg, time_next;
    logic [2:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       presence_reg, presence_next;
    logic [7:0] recv_reg, recv_next;

    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  result;

    logic       accept;
    logic [1:0] cur_drive;
    time_val_t  phase_len;
    logic [10:0] cnt;
    logic       last_bit;

    // Configuration port: write on the access cycle, read combinationally
    assign pready = 1'b1;
    assign prdata = {22'd0, cfg_reg[paddr[4:2]]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            cfg_reg[paddr[4:2]] <= pwdata[TIME_W-1:0];
        end
    end

    // Handshake: take a request when the result register is free or draining
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Select the duration of the current phase
    always_comb
    begin
        phase_len = cfg_reg[REG_SLOT_LOW];
        unique case (op_reg)
            OP_RESET:
            begin
                case (phase_reg)
                    PHASE_LOW: phase_len = cfg_reg[REG_RESET_LOW];
                    PHASE_MID: phase_len = cfg_reg[REG_PRESENCE_SMPL];
                    default:   phase_len = cfg_reg[REG_RESET_TAIL];
                endcase
            end
            OP_WRITE:
            begin
                case (phase_reg)
                    PHASE_LOW: phase_len = cfg_reg[REG_SLOT_LOW];
                    PHASE_MID: phase_len = cfg_reg[REG_WRITE_HOLD];
                    default:   phase_len = cfg_reg[REG_RECOVERY];
                endcase
            end
            default:
            begin
                case (phase_reg)
                    PHASE_LOW: phase_len = cfg_reg[REG_SLOT_LOW];
                    PHASE_MID: phase_len = cfg_reg[REG_READ_SMPL];
                    default:   phase_len = cfg_reg[REG_READ_TAIL];
                endcase
            end
        endcase
    end

    // Line level of the current phase
    always_comb
    begin
        if (op_reg == OP_IDLE)
            cur_drive = DRIVE_RELEASE;
        else if (phase_reg == PHASE_LOW)
            cur_drive = DRIVE_LOW;
        else if (op_reg == OP_WRITE && phase_reg == PHASE_MID)
            cur_drive = shift_reg[0] ? DRIVE_HIGH : DRIVE_LOW;
        else
            cur_drive = DRIVE_RELEASE;
    end

    assign cnt      = {1'b0, time_reg} + 11'd1;
    assign last_bit = ({1'b0, bit_reg} + 4'd1) >= BIT_LIMIT;

    // Sequencer: start or reject commands, advance phases on ticks
    always_comb
    begin
        op_next       = op_reg;
        phase_next    = phase_reg;
        time_next     = time_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        recv_next     = recv_reg;
        result        = '0;

        if (in_data.command != CMD_TICK)
        begin
            if (op_reg != OP_IDLE)
            begin
                result.rejected   = 1'b1;
                result.line_drive = cur_drive;
            end
            else
            begin
                op_next           = op_t'(in_data.command);
                phase_next        = PHASE_LOW;
                time_next         = '0;
                bit_next          = '0;
                shift_next        = (in_data.command == CMD_WRITE) ? in_data.write_byte : 8'd0;
                result.line_drive = DRIVE_LOW;
            end
        end
        else if (op_reg != OP_IDLE)
        begin
            result.line_drive = cur_drive;
            if (cnt >= {1'b0, phase_len})
            begin
                time_next = '0;
                // Sample the line at the end of the middle phase
                if (phase_reg == PHASE_MID && op_reg == OP_RESET)
                    presence_next = !in_data.line_in;
                if (phase_reg == PHASE_MID && op_reg == OP_READ && in_data.line_in)
                    shift_next = shift_reg | (8'd1 << bit_reg);
                if (phase_reg != PHASE_TAIL)
                begin
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    phase_next = PHASE_LOW;
                    if (op_reg == OP_RESET || last_bit)
                    begin
                        if (op_reg == OP_READ)
                            recv_next = shift_reg;
                        op_next         = OP_IDLE;
                        bit_next        = '0;
                        result.done_res = 1'b1;
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                        if (op_reg == OP_WRITE)
                            shift_next = shift_reg >> 1;
                    end
                end
            end
            else
            begin
                time_next = cnt[TIME_W-1:0];
            end
        end

        result.busy_res  = (op_next != OP_IDLE);
        result.presence  = presence_next;
        result.read_data = recv_next;
    end

    // Sequencer state: advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_IDLE;
            phase_reg    <= PHASE_LOW;
            time_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            recv_reg     <= '0;
        end
        else if (accept)
        begin
            op_reg       <= op_next;
            phase_reg    <= phase_next;
            time_reg     <= time_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            recv_reg     <= recv_next;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    // Checks on sequencer and result consistency
    `OWBM_ASSERT_IMPLY(a_busy_matches_op, clk, rst_n, out_valid_reg,
        out_data_reg.busy_res == (op_reg != OP_IDLE))
    `OWBM_ASSERT_ALWAYS(a_done_not_busy, clk, rst_n,
        !(out_valid_reg && out_data_reg.done_res && out_data_reg.busy_res))
    `OWBM_ASSERT_IMPLY(a_reject_when_busy, clk, rst_n,
        out_valid_reg && out_data_reg.rejected, out_data_reg.busy_res)
    `OWBM_ASSERT_IMPLY(a_idle_is_clear, clk, rst_n, op_reg == OP_IDLE,
        phase_reg == PHASE_LOW && time_reg == '0 && bit_reg == '0)

endmodule

/* verif/tb_one_wire_bus_master_top.sv */
// Self-checking testbench for the one-wire bus master: timed commands, checked bus status.
`timescale 1ns / 100ps

module tb_one_wire_bus_master_top;
    import owbm_pkg::*;

    localparam int BITS_PER_BYTE = 8;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Requests waiting to be sent and bus status predicted for accepted ones
    in_item_t    cmd_queue[$];
    out_item_t   status_due[$];
    int unsigned queued_items;
    int unsigned mismatches;
    int unsigned cycle_cnt;
    int          idle_mode;

    // Shadow of the master: timing registers and sequencer state
    time_val_t   m_timing[NUM_REGS];
    op_t         m_op;
    logic [1:0]  m_phase;
    logic [9:0]  m_count;
    logic [2:0]  m_bit;
    logic [7:0]  m_shift;
    logic        m_presence;
    logic [7:0]  m_rx;

    one_wire_bus_master_top #(
        .BITS_PER_BYTE(BITS_PER_BYTE)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // A register of zero counts as one tick
    function automatic int unsigned ticks_of(time_val_t v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Length of the phase the sequencer is in
    function automatic time_val_t slot_len();
        logic [2:0] idx;
        if (m_op == OP_RESET)
            idx = (m_phase == PHASE_LOW) ? REG_RESET_LOW :
                  (m_phase == PHASE_MID) ? REG_PRESENCE_SMPL : REG_RESET_TAIL;
        else if (m_op == OP_WRITE)
            idx = (m_phase == PHASE_LOW) ? REG_SLOT_LOW :
                  (m_phase == PHASE_MID) ? REG_WRITE_HOLD : REG_RECOVERY;
        else
            idx = (m_phase == PHASE_LOW) ? REG_SLOT_LOW :
                  (m_phase == PHASE_MID) ? REG_READ_SMPL : REG_READ_TAIL;
        return m_timing[idx];
    endfunction

    // Level the master puts on the line in its current phase
    function automatic logic [1:0] line_level();
        if (m_op == OP_IDLE)
            return DRIVE_RELEASE;
        if (m_phase == PHASE_LOW)
            return DRIVE_LOW;
        if (m_op == OP_WRITE && m_phase == PHASE_MID)
            return m_shift[0] ? DRIVE_HIGH : DRIVE_LOW;
        return DRIVE_RELEASE;
    endfunction

    // Advance the shadow master by one request and return its bus status
    function automatic out_item_t master_step(in_item_t req);
        out_item_t   st;
        logic [10:0] cnt;
        logic [1:0]  drive;
        logic        fin;
        logic        rej;
        drive = DRIVE_RELEASE;
        fin = 1'b0;
        rej = 1'b0;
        if (req.command != CMD_TICK)
        begin
            if (m_op != OP_IDLE)
                rej = 1'b1;
            else
            begin
                m_op    = op_t'(req.command);
                m_phase = PHASE_LOW;
                m_count = '0;
                m_bit   = '0;
                m_shift = (req.command == CMD_WRITE) ? req.write_byte : 8'h00;
            end
            drive = line_level();
        end
        else if (m_op != OP_IDLE)
        begin
            cnt = {1'b0, m_count} + 11'd1;
            drive = line_level();
            if (cnt >= {1'b0, slot_len()})
            begin
                m_count = '0;
                // sample on the last tick of the middle phase
                if (m_phase == PHASE_MID && m_op == OP_RESET)
                    m_presence = ~req.line_in;
                if (m_phase == PHASE_MID && m_op == OP_READ && req.line_in)
                    m_shift[m_bit] = 1'b1;
                if (m_phase != PHASE_TAIL)
                    m_phase = m_phase + 2'd1;
                else
                begin
                    m_phase = PHASE_LOW;
                    if (m_op == OP_RESET || int'(m_bit) + 1 >= BITS_PER_BYTE)
                    begin
                        if (m_op == OP_READ)
                            m_rx = m_shift;
                        m_op  = OP_IDLE;
                        m_bit = '0;
                        fin   = 1'b1;
                    end
                    else
                    begin
                        m_bit = m_bit + 3'd1;
                        if (m_op == OP_WRITE)
                            m_shift = m_shift >> 1;
                    end
                end
            end
            else
                m_count = cnt[9:0];
        end
        st.line_drive = drive;
        st.busy_res   = (m_op != OP_IDLE);
        st.done_res   = fin;
        st.presence   = m_presence;
        st.read_data  = m_rx;
        st.rejected   = rej;
        return st;
    endfunction

    // Random hold-off for the sending or the receiving side
    function automatic bit gap_roll(bit sender);
        int unsigned pct;
        if (idle_mode == 0)
            pct = sender ? 13 : 66;
        else if (idle_mode == 1)
            pct = sender ? 66 : 13;
        else
            pct = 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [1:0] pick_cmd();
        case ($urandom_range(0, 2))
            0:       return CMD_RESET;
            1:       return CMD_WRITE;
            default: return CMD_READ;
        endcase
    endfunction

    // Ticks a full command takes at the current timings
    function automatic int unsigned op_span(logic [1:0] cmd);
        if (cmd == CMD_RESET)
            return ticks_of(m_timing[REG_RESET_LOW]) + ticks_of(m_timing[REG_PRESENCE_SMPL])
                 + ticks_of(m_timing[REG_RESET_TAIL]);
        if (cmd == CMD_WRITE)
            return BITS_PER_BYTE * (ticks_of(m_timing[REG_SLOT_LOW])
                 + ticks_of(m_timing[REG_WRITE_HOLD]) + ticks_of(m_timing[REG_RECOVERY]));
        return BITS_PER_BYTE * (ticks_of(m_timing[REG_SLOT_LOW])
             + ticks_of(m_timing[REG_READ_SMPL]) + ticks_of(m_timing[REG_READ_TAIL]));
    endfunction

    task automatic push_req(logic [1:0] cmd, logic [7:0] wbyte, logic line);
        in_item_t r;
        r.command    = cmd;
        r.write_byte = wbyte;
        r.line_in    = line;
        cmd_queue.push_back(r);
        queued_items++;
    endtask

    // Queue a command and the ticks to carry it out; a loose one may be cut
    // short or carry stray commands in the middle
    task automatic gen_op(logic [1:0] cmd, logic [7:0] wbyte, bit clean);
        int unsigned ticks;
        int unsigned k;
        ticks = op_span(cmd) + $urandom_range(0, 3);
        if (!clean && $urandom_range(0, 3) == 0)
            ticks = $urandom_range(1, op_span(cmd));
        push_req(cmd, wbyte, 1'($urandom));
        for (k = 0; k < ticks; k++)
        begin
            if (!clean && $urandom_range(0, 39) == 0)
                push_req(pick_cmd(), 8'($urandom), 1'($urandom));
            push_req(CMD_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(int unsigned quota);
        int unsigned stop_at;
        int unsigned k;
        stop_at = queued_items + quota;
        while (queued_items < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    push_req(CMD_TICK, 8'($urandom), 1'($urandom));
            end
            else
                gen_op(pick_cmd(), 8'($urandom), $urandom_range(0, 7) != 0);
        end
    endtask

    // Wait until every request is sent and its status has come back
    task automatic drain();
        while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Drain, then tick until the master is idle
    task automatic finish_phase();
        drain();
        while (m_op != OP_IDLE)
        begin
            repeat (16) push_req(CMD_TICK, 8'($urandom), 1'($urandom));
            drain();
        end
    endtask

    // APB write: setup cycle, then access cycle
    task automatic set_timing(logic [2:0] idx, time_val_t val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~32'h3FF) | 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        m_timing[idx] = val;
    endtask

    // Send queued requests; predict each one as it is accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                status_due.push_back(master_step(in_data));
            if (!in_valid || !in_stall)
            begin
                if (cmd_queue.size() != 0 && !gap_roll(1'b1))
                begin
                    in_data  <= cmd_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check each accepted status against the oldest prediction
    always @(posedge clk)
    begin : status_check
        out_item_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (status_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected status: drive=%0d busy=%0d done=%0d",
                                 out_data.line_drive, out_data.busy_res, out_data.done_res);
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (out_data.line_drive !== want.line_drive
                        || out_data.busy_res !== want.busy_res
                        || out_data.done_res !== want.done_res
                        || out_data.presence !== want.presence
                        || out_data.read_data !== want.read_data
                        || out_data.rejected !== want.rejected)
                    begin
                        if (mismatches < 10)
                            $display({"status mismatch: expected drive=%0d busy=%0d done=%0d ",
                                      "pres=%0d data=%02h rej=%0d, got drive=%0d busy=%0d ",
                                      "done=%0d pres=%0d data=%02h rej=%0d"},
                                     want.line_drive, want.busy_res, want.done_res,
                                     want.presence, want.read_data, want.rejected,
                                     out_data.line_drive, out_data.busy_res,
                                     out_data.done_res, out_data.presence,
                                     out_data.read_data, out_data.rejected);
                        mismatches++;
                    end
                end
            end
            out_stall <= gap_roll(1'b0);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_one_wire_bus_master_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        idle_mode  = 0;
        mismatches = 0;
        cycle_cnt  = 0;
        queued_items = 0;
        for (i = 0; i < NUM_REGS; i++)
            m_timing[i] = CFG_RESET[i];
        m_op       = OP_IDLE;
        m_phase    = PHASE_LOW;
        m_count    = '0;
        m_bit      = '0;
        m_shift    = '0;
        m_presence = 1'b0;
        m_rx       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default timings straight out of reset
        gen_op(CMD_RESET, 8'($urandom), 1'b1);
        finish_phase();

        // shortest timings: directed cases first
        for (i = 0; i < NUM_REGS; i++)
            set_timing(3'(i), 10'd1);
        push_req(CMD_TICK, 8'hFF, 1'b1);
        push_req(CMD_RESET, 8'h00, 1'b0);
        push_req(CMD_WRITE, 8'hA5, 1'b1);
        push_req(CMD_TICK, 8'h00, 1'b1);
        push_req(CMD_TICK, 8'h00, 1'b0);
        push_req(CMD_TICK, 8'h00, 1'b1);
        push_req(CMD_READ, 8'hFF, 1'b0);
        push_req(CMD_RESET, 8'h5A, 1'b0);
        for (i = 0; i < 3 * BITS_PER_BYTE; i++)
            push_req(CMD_TICK, 8'($urandom), 1'b1);
        run_random(250);
        finish_phase();

        // short random timings, sender idles more
        idle_mode = 1;
        for (i = 0; i < NUM_REGS; i++)
            set_timing(3'(i), 10'($urandom_range(1, 6)));
        run_random(250);
        finish_phase();

        // no idling on either side
        idle_mode = 2;
        for (i = 0; i < NUM_REGS; i++)
            set_timing(3'(i), 10'($urandom_range(1, 8)));
        run_random(250);
        finish_phase();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("tb_one_wire_bus_master_top OK");
        else
            $display("tb_one_wire_bus_master_top NOT OK");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/owbm_pkg.sv
rtl/core/one_wire_bus_master_top.sv
verif/tb_one_wire_bus_master_top.sv
